>>> rtl/core/trial_division_factorizer_macros.svh
`ifndef TRIAL_DIVISION_FACTORIZER_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TDF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TDF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/core/tdf_pkg.sv
package tdf_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_BOUND,
		ST_FINAL,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		DS_TWO,
		DS_THREE,
		DS_LOW,
		DS_HIGH
	} dv_stage_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic take_quot;
		logic advance;
		logic record_div;
		logic record_rem;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic      small_val;
		logic      div_done;
		logic      rem_zero;
		logic      e_nz;
		logic      cnt_full;
		dv_stage_t stage;
		logic      bound_ok;
		logic      rem_gt1;
		logic      out_free;
		logic      emit_last;
	} dp_sts_t;

	localparam int DIV_FIRST   = 2;
	localparam int DIV_SECOND  = 3;
	localparam int DIV_BASE    = 5;
	localparam int DIV_STEP    = 6;
	localparam int HIGH_OFFSET = 2;
	localparam int OUT_WIDTH   = 32;
	localparam int EXP_WIDTH   = 6;

endpackage

>>> rtl/core/tdf_ctrl.sv
module tdf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tdf_pkg::dp_sts_t sts,
	output tdf_pkg::dp_cmd_t cmd
);
	import tdf_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.small_val ? ST_EMIT : ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done && !sts.rem_zero) begin
					if (sts.stage == DS_THREE || sts.stage == DS_HIGH) begin
						state_d = ST_BOUND;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_BOUND: begin
				state_d = sts.bound_ok ? ST_DIV : ST_FINAL;
			end
			ST_FINAL: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free && sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_DIV: begin
				if (!sts.div_done) begin
					cmd.div_step = 1'b1;
				end else if (sts.rem_zero) begin
					cmd.take_quot = 1'b1;
				end else begin
					cmd.advance    = 1'b1;
					cmd.record_div = sts.e_nz && !sts.cnt_full;
				end
			end
			ST_FINAL: begin
				cmd.record_rem = sts.rem_gt1 && !sts.cnt_full;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/tdf_datapath.sv
module tdf_datapath #(
	parameter int WIDTH       = 32,
	parameter int MAX_FACTORS = 9
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [WIDTH-1:0]                   value,
	input  tdf_pkg::dp_cmd_t                   cmd,
	output tdf_pkg::dp_sts_t                   sts,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tdf_pkg::OUT_WIDTH-1:0]      prime_factor,
	output logic [tdf_pkg::EXP_WIDTH-1:0]      exponent,
	output logic                               last
);
	import tdf_pkg::*;
	`include "trial_division_factorizer_macros.svh"

	localparam int SW  = 2 * WIDTH;
	localparam int DCW = $clog2(WIDTH + 1);
	localparam int CW  = $clog2(MAX_FACTORS + 1);
	localparam int IW  = $clog2(MAX_FACTORS);

	logic [WIDTH-1:0]     rem_q, dv_q, base_q, r_q, quo_q;
	logic [SW-1:0]        sq_q;
	logic [DCW-1:0]       dcnt_q;
	logic [EXP_WIDTH-1:0] e_q;
	logic [CW-1:0]        cnt_q;
	dv_stage_t            stage_q;
	logic [WIDTH-1:0]     list_p_q [MAX_FACTORS];
	logic [EXP_WIDTH-1:0] list_e_q [MAX_FACTORS];
	logic                 out_valid_q;
	logic [OUT_WIDTH-1:0] out_p_q;
	logic [EXP_WIDTH-1:0] out_e_q;
	logic                 out_last_q;

	logic [WIDTH:0]   r_sh, diff;
	logic [IW-1:0]    wr_idx, rd_idx;
	logic [CW-1:0]    cnt_m1;

	assign r_sh   = {r_q, quo_q[WIDTH-1]};
	assign diff   = r_sh - {1'b0, dv_q};
	assign wr_idx = cnt_q[IW-1:0];
	assign cnt_m1 = cnt_q - CW'(1);
	assign rd_idx = cnt_m1[IW-1:0];

	always_comb begin
		sts           = '0;
		sts.small_val = value < WIDTH'(2);
		sts.div_done  = dcnt_q == DCW'(WIDTH);
		sts.rem_zero  = r_q == '0;
		sts.e_nz      = e_q != '0;
		sts.cnt_full  = cnt_q == CW'(MAX_FACTORS);
		sts.stage     = stage_q;
		sts.bound_ok  = sq_q <= SW'(rem_q);
		sts.rem_gt1   = rem_q > WIDTH'(1);
		sts.out_free  = !out_valid_q || !out_stall;
		sts.emit_last = cnt_q == CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q      <= '0;
			e_q         <= '0;
			cnt_q       <= '0;
			stage_q     <= DS_TWO;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				dcnt_q  <= '0;
				e_q     <= '0;
				stage_q <= DS_TWO;
				cnt_q   <= (value < WIDTH'(2)) ? CW'(1) : '0;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DCW'(1);
			end
			if (cmd.take_quot) begin
				dcnt_q <= '0;
				e_q    <= e_q + EXP_WIDTH'(1);
			end
			if (cmd.advance) begin
				dcnt_q <= '0;
				e_q    <= '0;
				case (stage_q)
					DS_TWO:   stage_q <= DS_THREE;
					DS_THREE: stage_q <= DS_LOW;
					DS_LOW:   stage_q <= DS_HIGH;
					DS_HIGH:  stage_q <= DS_LOW;
					default:  stage_q <= DS_TWO;
				endcase
			end
			if (cmd.record_div || cmd.record_rem) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.emit) begin
				cnt_q       <= cnt_m1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= value;
			dv_q  <= WIDTH'(DIV_FIRST);
			r_q   <= '0;
			quo_q <= value;
			if (value < WIDTH'(2)) begin
				list_p_q[0] <= '0;
				list_e_q[0] <= '0;
			end
		end
		if (cmd.div_step) begin
			if (!diff[WIDTH]) begin
				r_q <= diff[WIDTH-1:0];
			end else begin
				r_q <= r_sh[WIDTH-1:0];
			end
			quo_q <= {quo_q[WIDTH-2:0], ~diff[WIDTH]};
		end
		if (cmd.take_quot) begin
			rem_q <= quo_q;
			r_q   <= '0;
		end
		if (cmd.advance) begin
			r_q   <= '0;
			quo_q <= rem_q;
			case (stage_q)
				DS_TWO: begin
					dv_q <= WIDTH'(DIV_SECOND);
				end
				DS_THREE: begin
					dv_q   <= WIDTH'(DIV_BASE);
					base_q <= WIDTH'(DIV_BASE);
					sq_q   <= SW'(DIV_BASE * DIV_BASE);
				end
				DS_LOW: begin
					dv_q <= base_q + WIDTH'(HIGH_OFFSET);
				end
				default: begin
					dv_q   <= base_q + WIDTH'(DIV_STEP);
					base_q <= base_q + WIDTH'(DIV_STEP);
					sq_q   <= sq_q + (SW'(base_q) << 3) + (SW'(base_q) << 2)
						+ SW'(DIV_STEP * DIV_STEP);
				end
			endcase
		end
		if (cmd.take_quot) begin
			quo_q <= quo_q;
		end
		if (cmd.record_div) begin
			list_p_q[wr_idx] <= dv_q;
			list_e_q[wr_idx] <= e_q;
		end
		if (cmd.record_rem) begin
			list_p_q[wr_idx] <= rem_q;
			list_e_q[wr_idx] <= EXP_WIDTH'(1);
		end
		if (cmd.emit) begin
			out_p_q    <= OUT_WIDTH'(list_p_q[rd_idx]);
			out_e_q    <= list_e_q[rd_idx];
			out_last_q <= cnt_q == CW'(1);
		end
	end

	assign out_valid    = out_valid_q;
	assign prime_factor = out_p_q;
	assign exponent     = out_e_q;
	assign last         = out_last_q;

	`TDF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_FACTORS))
	`TDF_ASSERT_NEXT(a_last_drains, cmd.emit && cnt_q == CW'(1), cnt_q == '0)
	`TDF_ASSERT_NOW(a_emit_nonempty, cmd.emit, cnt_q != '0)
	`TDF_ASSERT_NOW(a_dv_nonzero, cmd.div_step, dv_q != '0)

endmodule

>>> rtl/core/trial_division_factorizer.sv
// Each value is factorized by trial division, with every division of the remainder by a
// candidate done in the WIDTH-step bit-serial divider.
// Throughput: one value at a time; the next value is taken once the last pair is loaded.
// Reset: arst_n clears the controller state and output valid asynchronously.
module trial_division_factorizer #(
	parameter int WIDTH       = 32,
	parameter int MAX_FACTORS = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [WIDTH-1:0]              value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tdf_pkg::OUT_WIDTH-1:0] prime_factor,
	output logic [tdf_pkg::EXP_WIDTH-1:0] exponent,
	output logic                          last
);
	import tdf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	tdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdf_datapath #(
		.WIDTH       (WIDTH),
		.MAX_FACTORS (MAX_FACTORS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.prime_factor (prime_factor),
		.exponent     (exponent),
		.last         (last)
	);

endmodule

>>> sim/tb_top.sv
module tb_top;
	import tdf_pkg::*;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] prime;
		logic [EXP_WIDTH-1:0] mult;
		logic                 fin;
	} factor_t;

	localparam int MAX_PAIRS = 9;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [31:0]          value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [OUT_WIDTH-1:0] prime_factor;
	logic [EXP_WIDTH-1:0] exponent;
	logic                 last;

	factor_t pending_factors[$];
	int      mismatches = 0;
	int      send_gap_pct = 0;
	int      recv_gap_pct = 0;
	int      hold_cycles = 0;

	trial_division_factorizer #(.WIDTH(32), .MAX_FACTORS(MAX_PAIRS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.prime_factor(prime_factor),
		.exponent(exponent),
		.last(last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 8_000_000);
		$display("== FAIL ==");
		$finish;
	end

	function automatic void factorize(input logic [31:0] v);
		logic [31:0] rest;
		logic [63:0] cand;
		logic [31:0] primes[MAX_PAIRS];
		logic [5:0]  mults[MAX_PAIRS];
		logic [5:0]  m;
		int          cnt;
		factor_t     f;
		rest = v;
		cnt = 0;
		if (rest < 2) begin
			f.prime = '0;
			f.mult = '0;
			f.fin = 1'b1;
			pending_factors.push_back(f);
			return;
		end
		cand = 2;
		while (cand < 5 || cand * cand <= rest) begin
			m = 0;
			while (rest % cand[31:0] == 0) begin
				rest = rest / cand[31:0];
				m++;
			end
			if (m != 0 && cnt < MAX_PAIRS) begin
				primes[cnt] = cand[31:0];
				mults[cnt] = m;
				cnt++;
			end
			if (cand == 2)
				cand = 3;
			else if (cand == 3)
				cand = 5;
			else if (cand % 6 == 5)
				cand = cand + 2;
			else
				cand = cand + 4;
		end
		if (rest > 1 && cnt < MAX_PAIRS) begin
			primes[cnt] = rest;
			mults[cnt] = 1;
			cnt++;
		end
		for (int k = cnt - 1; k >= 0; k--) begin
			f.prime = primes[k];
			f.mult = mults[k];
			f.fin = (k == 0);
			pending_factors.push_back(f);
		end
	endfunction

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		factor_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_factors.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: prime %0d exp %0d last %0b",
						prime_factor, exponent, last);
			end else begin
				want = pending_factors.pop_front();
				if (want.prime !== prime_factor || want.mult !== exponent
						|| want.fin !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d^%0d last %0b, got %0d^%0d last %0b",
							want.prime, want.mult, want.fin, prime_factor, exponent, last);
				end
			end
		end
	end

	task automatic send_value(input logic [31:0] v);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (in_stall);
		factorize(v);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_factors.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		logic [63:0] acc;
		logic [63:0] p;
		int          pick;
		int          small_primes[10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return $urandom_range(2, 65535);
		if (pick < 70)
			return 32'($urandom_range(1, 65535)) << $urandom_range(0, 16);
		if (pick < 90) begin
			acc = 1;
			repeat ($urandom_range(1, 12)) begin
				p = small_primes[$urandom_range(0, 9)];
				if (acc * p <= 64'hFFFF_FFFF)
					acc = acc * p;
			end
			return acc[31:0];
		end
		return $urandom_range(0, 3);
	endfunction

	task automatic test_directed();
		logic [31:0] corner[22] = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd25, 32'd35,
			32'd49, 32'd143, 32'd30030, 32'd510510, 32'd9699690, 32'd223092870,
			32'h8000_0000, 32'd3486784401, 32'hFFFF_FFFF, 32'd65521,
			32'd4294836225, 32'd65537, 32'd1024
		};
		send_gap_pct = 0;
		recv_gap_pct = 0;
		foreach (corner[i])
			send_value(corner[i]);
		wait_drained();
	endtask

	task automatic test_random(input int tx_pct, input int rx_pct, input int count);
		send_gap_pct = tx_pct;
		recv_gap_pct = rx_pct;
		repeat (count)
			send_value(random_value());
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_gap_pct = 0;
		@(negedge clk);
		hold_cycles = 3000;
		repeat (6)
			send_value($urandom_range(2, 4000));
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(27, 77, 24);
		test_random(77, 27, 24);
		test_random(0, 0, 24);
		test_backpressure();
		if (mismatches == 0 && pending_factors.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
